// ----- hw/rtl/fixed_block_free_list_allocator_assert.svh -----
// Assertion macros used by the allocator's checker file.
// Needs no package; callers pass clock, reset and the expressions.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FBFL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fbfl_pkg.sv -----
// Package for the fixed-size block allocator: sizes, codes and word types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fbfl_pkg;

  localparam int MAX_BLOCKS = 1024;
  localparam int WORD_BYTES = 8;
  localparam int WORD_SHIFT = $clog2(WORD_BYTES);
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int BB_W       = 16;
  localparam int ALIGN_W    = 17;
  localparam int ADDR_W     = 32;
  localparam int PROD_W     = IDX_W + ALIGN_W;
  localparam int DIV_STEPS  = ADDR_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_TOO_SMALL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 2'd2;

  localparam logic [BB_W-1:0] BLOCK_BYTES_RESET = 16'd8;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  granted_index;
    logic [ADDR_W-1:0] granted_address;
    logic [CNT_W-1:0]  free_blocks;
  } out_item_t;

  // One entry of the link memory: the end mark and the next block.
  typedef struct packed {
    logic             last;
    logic [IDX_W-1:0] next;
  } link_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic div_load;
    logic div_step;
    logic link_step;
    logic alloc_read;
    logic done_init;
    logic done_alloc;
    logic done_free;
    logic done_nop;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cfg_ok;
    logic div_last;
    logic link_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fixed_block_free_list_allocator.sv -----
// Fixed-size block allocator with a LIFO free list kept in a 1024-entry link memory.
// A word is accepted on the input channel when the block is idle, and its one result
// word is held in an output register, so the next word can be taken while a result
// waits. Alloc passes an extra state, beside free and the unused command, for the
// registered link memory read, which also forms the index times block size product;
// the result word appears in the same cycle that the next word can be taken. Init
// runs a bit-serial divider for the block count, then writes the link memory one
// entry per cycle, for at most 1024 linked blocks. An init whose segment is smaller
// than its misalignment plus the header word, or whose block size is zero, skips
// the divider. A result held by out_ready stalls the finish of the next word until
// that result is taken. Configuration writes are always taken and apply at once, so
// make them only while no word is in flight. Depends on fbfl_pkg, fbfl_dp and
// fbfl_ctrl.
`default_nettype none

module fixed_block_free_list_allocator import fbfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  fbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .stat     (stat),
    .cmd      (cmd)
  );

  fbfl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/fbfl_dp.sv -----
// Datapath of the block allocator: registers, divider, link memory, result word.
// Depends on fbfl_pkg; driven by the fbfl_ctrl command struct.
`default_nettype none

module fbfl_dp import fbfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  in_item_t             in_item,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item
);

  // Configuration registers.
  logic [ADDR_W-1:0] seg_base_r;
  logic [ADDR_W-1:0] seg_bytes_r;
  logic [BB_W-1:0]   block_bytes_r;

  // Allocator state.
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic               empty_r, empty_nxt;
  logic [CNT_W-1:0]   free_cnt_r, free_cnt_nxt;
  logic [ALIGN_W-1:0] aligned_r, aligned_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;

  // Init work registers.
  logic [ALIGN_W:0]     rem_r;
  logic [ADDR_W-1:0]    quo_r;
  logic [ALIGN_W-1:0]   den_r;
  logic [DIV_CNT_W-1:0] step_r;
  logic                 ok_r;
  logic [IDX_W-1:0]     ptr_r;

  logic [IDX_W-1:0]  idx_r;
  logic [PROD_W-1:0] prod_r;
  link_t             rd_r;
  link_t             link_mem [MAX_BLOCKS];

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic [ALIGN_W-1:0]  aligned_calc;
  logic [WORD_SHIFT-1:0] mis;
  logic [ADDR_W:0]     need;
  logic                cfg_ok;
  logic [ADDR_W-1:0]   dividend;
  logic [ALIGN_W:0]    shifted;
  logic [ALIGN_W:0]    diff;
  logic                fits;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    ptr_inc;
  logic                free_hit;
  logic                out_free;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  link_t               wdata;

  assign aligned_calc = ((ALIGN_W'(block_bytes_r) + ALIGN_W'(WORD_BYTES - 1)) >> WORD_SHIFT)
                        << WORD_SHIFT;
  assign mis      = seg_base_r[WORD_SHIFT-1:0];
  assign need     = (ADDR_W+1)'(mis) + (ADDR_W+1)'(WORD_BYTES);
  assign cfg_ok   = ({1'b0, seg_bytes_r} >= need) && (aligned_calc != '0);
  assign dividend = seg_bytes_r - ADDR_W'(mis) - ADDR_W'(WORD_BYTES);

  // One restoring step: bring in the next dividend bit and try the subtract.
  assign shifted = {rem_r[ALIGN_W-1:0], quo_r[ADDR_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    if (!ok_r) begin
      count = '0;
    end else if (quo_r > ADDR_W'(MAX_BLOCKS)) begin
      count = CNT_W'(MAX_BLOCKS);
    end else begin
      count = quo_r[CNT_W-1:0];
    end
  end

  assign ptr_inc  = {1'b0, ptr_r} + CNT_W'(1);
  assign free_hit = {1'b0, idx_r} < total_r;
  assign out_free = !out_valid_r || out_ready;

  assign stat.cfg_ok    = cfg_ok;
  assign stat.div_last  = step_r == DIV_CNT_W'(DIV_STEPS - 1);
  assign stat.link_last = (count == '0) || (ptr_inc == count);
  assign stat.out_free  = out_free;

  // Link memory write port: the init sweep or a free.
  always_comb begin
    we    = 1'b0;
    waddr = ptr_r;
    wdata = '{last: ptr_inc == count, next: ptr_inc[IDX_W-1:0]};
    if (cmd.link_step && count != '0) begin
      we = 1'b1;
    end else if (cmd.done_free && free_hit) begin
      we    = 1'b1;
      waddr = idx_r;
      wdata = '{last: empty_r, next: empty_r ? '0 : head_r};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      link_mem[waddr] <= wdata;
    end
    if (cmd.alloc_read) begin
      rd_r <= link_mem[head_r];
    end
  end

  always_comb begin
    head_nxt      = head_r;
    empty_nxt     = empty_r;
    free_cnt_nxt  = free_cnt_r;
    aligned_nxt   = aligned_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    if (cmd.done_init) begin
      aligned_nxt  = den_r;
      total_nxt    = count;
      free_cnt_nxt = count;
      head_nxt     = '0;
      empty_nxt    = count == '0;
    end else if (cmd.done_alloc && !empty_r) begin
      head_nxt  = rd_r.last ? '0 : rd_r.next;
      empty_nxt = rd_r.last;
      if (free_cnt_r != '0) begin
        free_cnt_nxt = free_cnt_r - CNT_W'(1);
      end
    end else if (cmd.done_free && free_hit) begin
      head_nxt  = idx_r;
      empty_nxt = 1'b0;
      if (free_cnt_r < total_r) begin
        free_cnt_nxt = free_cnt_r + CNT_W'(1);
      end
    end

    if (cmd.done_init || cmd.done_alloc || cmd.done_free || cmd.done_nop) begin
      out_valid_nxt                = 1'b1;
      out_item_nxt.status          = ST_OK;
      out_item_nxt.granted_index   = '0;
      out_item_nxt.granted_address = '0;
      out_item_nxt.free_blocks     = free_cnt_nxt;
      if (cmd.done_init && count == '0) begin
        out_item_nxt.status = ST_TOO_SMALL;
      end
      if (cmd.done_alloc) begin
        if (empty_r) begin
          out_item_nxt.status = ST_EMPTY;
        end else begin
          out_item_nxt.granted_index   = head_r;
          out_item_nxt.granted_address = seg_base_r + ADDR_W'(WORD_BYTES) + ADDR_W'(prod_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_base_r    <= '0;
      seg_bytes_r   <= '0;
      block_bytes_r <= BLOCK_BYTES_RESET;
      head_r        <= '0;
      empty_r       <= 1'b1;
      free_cnt_r    <= '0;
      aligned_r     <= '0;
      total_r       <= '0;
      out_valid_r   <= 1'b0;
      step_r        <= '0;
      ptr_r         <= '0;
      ok_r          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SEGMENT_BASE:  seg_base_r    <= cfg_data;
          CFG_SEGMENT_BYTES: seg_bytes_r   <= cfg_data;
          CFG_BLOCK_BYTES:   block_bytes_r <= cfg_data[BB_W-1:0];
          default: ;
        endcase
      end
      head_r      <= head_nxt;
      empty_r     <= empty_nxt;
      free_cnt_r  <= free_cnt_nxt;
      aligned_r   <= aligned_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.div_load) begin
        step_r <= '0;
        ptr_r  <= '0;
        ok_r   <= cfg_ok;
      end else begin
        if (cmd.div_step) begin
          step_r <= step_r + DIV_CNT_W'(1);
        end
        if (cmd.link_step) begin
          ptr_r <= ptr_inc[IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (cmd.capture) begin
      idx_r <= in_item.block_index;
    end
    if (cmd.div_load) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= aligned_calc;
    end else if (cmd.div_step) begin
      rem_r <= fits ? diff : shifted;
      quo_r <= {quo_r[ADDR_W-2:0], fits};
    end
    if (cmd.alloc_read) begin
      prod_r <= PROD_W'(head_r) * PROD_W'(aligned_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- hw/rtl/fbfl_ctrl.sv -----
// Controller state machine of the block allocator: sequences init, alloc, free and the unused command.
// Depends on fbfl_pkg; drives the fbfl_dp command struct.
`default_nettype none

module fbfl_ctrl import fbfl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LINK,
    S_INIT_DONE,
    S_ALLOC_RD,
    S_ALLOC_WB,
    S_FREE,
    S_NOP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture = 1'b1;
          case (in_item.command)
            CMD_INIT: begin
              cmd.div_load = 1'b1;
              state_nxt    = stat.cfg_ok ? S_DIV : S_LINK;
            end
            CMD_ALLOC: state_nxt = S_ALLOC_RD;
            CMD_FREE:  state_nxt = S_FREE;
            default:   state_nxt = S_NOP;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link_step = 1'b1;
        if (stat.link_last) begin
          state_nxt = S_INIT_DONE;
        end
      end
      S_INIT_DONE: begin
        if (stat.out_free) begin
          cmd.done_init = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ALLOC_RD: begin
        cmd.alloc_read = 1'b1;
        state_nxt      = S_ALLOC_WB;
      end
      S_ALLOC_WB: begin
        if (stat.out_free) begin
          cmd.done_alloc = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_FREE: begin
        if (stat.out_free) begin
          cmd.done_free = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_NOP: begin
        if (stat.out_free) begin
          cmd.done_nop = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= state_nxt == S_IDLE;
    end
  end

  assign in_ready = in_ready_r;

endmodule

`default_nettype wire

// ----- hw/rtl/fbfl_checker.sv -----
// Port-level checker for the block allocator and its bind to the top level.
// Depends on fbfl_pkg and fixed_block_free_list_allocator_assert.svh.
`default_nettype none
`include "fixed_block_free_list_allocator_assert.svh"

module fbfl_checker import fbfl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  `FBFL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item), "result word changed while stalled")

  // An empty list always goes with a zero free count and no grant.
  `FBFL_ASSERT_IMP(a_empty_zero, clk, rst_n, out_valid && out_item.status == ST_EMPTY, out_item.granted_index == '0 && out_item.granted_address == '0 && out_item.free_blocks == '0, "empty answer carries a grant or free blocks")

  `FBFL_ASSERT_IMP(a_small_zero, clk, rst_n, out_valid && out_item.status == ST_TOO_SMALL, out_item.free_blocks == '0 && out_item.granted_address == '0, "too-small init left free blocks")

  `FBFL_ASSERT_IMP(a_grant_ok, clk, rst_n, out_valid && out_item.granted_index != '0, out_item.status == ST_OK, "grant with a failing status")

  `FBFL_ASSERT_IMP(a_free_max, clk, rst_n, out_valid, out_item.free_blocks <= CNT_W'(MAX_BLOCKS), "free count beyond the block limit")

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the fixed-size block allocator with its LIFO free list.
// Mirrors the allocator state to predict every result word; needs fbfl_pkg and the RTL.

module testbench;
  import fbfl_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_HOLD = 240;
  localparam int SETTLE_CYCLES = 20;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  // Mirror of the allocator registers and free list.
  logic [ADDR_W-1:0]  reg_base;
  logic [ADDR_W-1:0]  reg_bytes;
  logic [BB_W-1:0]    reg_block_bytes;
  logic [IDX_W-1:0]   head_block;
  logic               list_is_empty;
  logic [IDX_W-1:0]   next_block [MAX_BLOCKS];
  logic               is_tail [MAX_BLOCKS];
  logic [CNT_W-1:0]   free_total;
  logic [ALIGN_W-1:0] block_stride;
  logic [CNT_W-1:0]   block_total;

  out_item_t        expected_replies [$];
  logic [IDX_W-1:0] held_blocks [$];
  int               errors = 0;
  int               idle_pct = 25;
  int               hold_requests = 0;

  fixed_block_free_list_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_item_t predict_reply(input in_item_t w);
    out_item_t        r;
    longint unsigned  al;
    longint unsigned  mis;
    longint unsigned  cnt;
    longint unsigned  addr;
    logic [IDX_W-1:0] idx;
    r = '0;
    case (w.command)
      CMD_INIT: begin
        al = reg_block_bytes;
        al = (al + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;
        mis = reg_base % WORD_BYTES;
        cnt = 0;
        if (reg_bytes >= mis + WORD_BYTES && al != 0)
          cnt = (reg_bytes - mis - WORD_BYTES) / al;
        if (cnt > MAX_BLOCKS)
          cnt = MAX_BLOCKS;
        block_stride = ALIGN_W'(al);
        block_total = CNT_W'(cnt);
        free_total = CNT_W'(cnt);
        head_block = '0;
        list_is_empty = (cnt == 0);
        for (int i = 0; i < cnt; i++) begin
          next_block[i] = IDX_W'(i + 1);
          is_tail[i] = (i + 1 == cnt);
        end
        r.status = (cnt == 0) ? ST_TOO_SMALL : ST_OK;
      end
      CMD_ALLOC: begin
        if (list_is_empty) begin
          r.status = ST_EMPTY;
        end else begin
          idx = head_block;
          if (is_tail[idx]) begin
            list_is_empty = 1'b1;
            head_block = '0;
          end else begin
            head_block = next_block[idx];
          end
          if (free_total != 0)
            free_total--;
          addr = reg_base;
          addr = addr + WORD_BYTES + idx * block_stride;
          r.status = ST_OK;
          r.granted_index = idx;
          r.granted_address = addr[ADDR_W-1:0];
        end
      end
      CMD_FREE: begin
        // Indices past the end of the segment are dropped; double frees are not.
        if (w.block_index < block_total) begin
          next_block[w.block_index] = list_is_empty ? '0 : head_block;
          is_tail[w.block_index] = list_is_empty;
          head_block = w.block_index;
          list_is_empty = 1'b0;
          if (free_total < block_total)
            free_total++;
        end
        r.status = ST_OK;
      end
      CMD_NOP: r.status = ST_OK;
    endcase
    r.free_blocks = free_total;
    return r;
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [IDX_W-1:0] idx);
    in_item_t  w;
    out_item_t r;
    w.command = cmd;
    w.block_index = idx;
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    r = predict_reply(w);
    expected_replies.push_back(r);
    if (cmd == CMD_INIT)
      held_blocks.delete();
    else if (cmd == CMD_ALLOC && r.status == ST_OK)
      held_blocks.push_back(r.granted_index);
  endtask

  // Leaves cfg_valid high so that back-to-back writes need no second assignment.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_SEGMENT_BASE:  reg_base = data;
      CFG_SEGMENT_BYTES: reg_bytes = data;
      CFG_BLOCK_BYTES:   reg_block_bytes = data[BB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_regs(input logic [2:0] mask, input logic [ADDR_W-1:0] base,
                            input logic [ADDR_W-1:0] bytes, input logic [BB_W-1:0] bb);
    if (mask[0])
      write_reg(CFG_SEGMENT_BASE, base);
    if (mask[1])
      write_reg(CFG_SEGMENT_BYTES, bytes);
    if (mask[2])
      write_reg(CFG_BLOCK_BYTES, {{(ADDR_W-BB_W){1'b0}}, bb});
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  // Sizes the segment so that init links exactly n blocks, with random slack.
  task automatic configure_for_blocks(input logic [ADDR_W-1:0] base,
                                      input logic [BB_W-1:0] bb, input int n);
    longint unsigned al;
    longint unsigned bytes;
    al = bb;
    al = (al + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;
    bytes = base % WORD_BYTES + WORD_BYTES + n * al + $urandom_range(0, 32'(al - 1));
    write_regs(3'b111, base, bytes[ADDR_W-1:0], bb);
  endtask

  task automatic run_mixed_traffic(input int n, input int alloc_pct);
    int               pick;
    int               slot;
    logic [IDX_W-1:0] victim;
    send_word(CMD_INIT, IDX_W'($urandom));
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        send_word(CMD_ALLOC, IDX_W'($urandom));
      end else if (pick < 90 && held_blocks.size() != 0) begin
        slot = $urandom_range(0, held_blocks.size() - 1);
        victim = held_blocks[slot];
        held_blocks.delete(slot);
        send_word(CMD_FREE, victim);
      end else if (pick < 94) begin
        send_word(CMD_FREE, IDX_W'($urandom));
      end else if (pick < 97) begin
        send_word(CMD_FREE, IDX_W'($urandom_range(0, block_total)));
      end else if (pick < 99) begin
        send_word(CMD_NOP, IDX_W'($urandom));
      end else begin
        send_word(CMD_INIT, IDX_W'($urandom));
      end
    end
    wait_for_results();
  endtask

  task automatic test_after_reset();
    send_word(CMD_ALLOC, '0);
    send_word(CMD_FREE, '0);
    send_word(CMD_NOP, 10'h3FF);
    send_word(CMD_INIT, '0);
    wait_for_results();
  endtask

  task automatic test_small_segment();
    // A base of 3 and 9-byte blocks rounded to 16 leave room for five blocks.
    write_regs(3'b111, 32'd3, 32'd98, 16'd9);
    send_word(CMD_INIT, '0);
    repeat (6) send_word(CMD_ALLOC, '0);
    send_word(CMD_FREE, 10'd4);
    send_word(CMD_FREE, 10'd4);
    send_word(CMD_FREE, 10'd2);
    send_word(CMD_FREE, 10'd5);
    send_word(CMD_FREE, 10'h3FF);
    repeat (3) send_word(CMD_ALLOC, '0);
    wait_for_results();
    // The new base applies to the next grant without an init.
    write_regs(3'b001, 32'hFFFF_FFFF, '0, '0);
    send_word(CMD_ALLOC, '0);
    wait_for_results();
    // Fourteen bytes at a misalignment of seven cannot hold the header word and a block.
    write_regs(3'b010, '0, 32'd14, '0);
    send_word(CMD_INIT, '0);
    send_word(CMD_ALLOC, '0);
    wait_for_results();
    write_regs(3'b110, '0, 32'd1000, 16'd0);
    send_word(CMD_INIT, '0);
    wait_for_results();
  endtask

  task automatic test_extremes();
    write_regs(3'b110, '0, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(CMD_INIT, '0);
    send_word(CMD_FREE, 10'h3FF);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_ALLOC, '0);
    wait_for_results();
    write_regs(3'b101, 32'd0, '0, 16'd1);
    send_word(CMD_INIT, '0);
    send_word(CMD_ALLOC, '0);
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    configure_for_blocks($urandom, 16'd24, 16);
    hold_requests++;
    run_mixed_traffic(24, 60);
  endtask

  task automatic test_random_traffic();
    idle_pct = 30;
    configure_for_blocks($urandom, BB_W'($urandom_range(1, 40)), $urandom_range(1, 8));
    run_mixed_traffic(370, 50);
    idle_pct = 15;
    configure_for_blocks($urandom, BB_W'($urandom_range(1, 300)), $urandom_range(20, 60));
    run_mixed_traffic(370, 60);
    idle_pct = 40;
    configure_for_blocks($urandom_range(32'hFFFF_FF00, 32'hFFFF_FFFF),
                         BB_W'($urandom_range(40000, 65535)), $urandom_range(1, 30));
    run_mixed_traffic(370, 45);
    idle_pct = 20;
    write_regs(3'b111, $urandom, 32'hFFFF_FFFF, BB_W'($urandom_range(1, 4000)));
    run_mixed_traffic(370, 45);
    idle_pct = 0;
    configure_for_blocks($urandom, BB_W'($urandom_range(1, 64)), $urandom_range(2, 24));
    run_mixed_traffic(370, 50);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    reg_base = '0;
    reg_bytes = '0;
    reg_block_bytes = BLOCK_BYTES_RESET;
    head_block = '0;
    list_is_empty = 1'b1;
    free_total = '0;
    block_stride = '0;
    block_total = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      next_block[i] = '0;
      is_tail[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_small_segment();
    test_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin : result_checker
    out_item_t want;
    int        stall_left;
    int        holds_served;
    stall_left = 0;
    holds_served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("result word with none expected: %h", out_item);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_item.status);
            errors++;
          end
          if (out_item.granted_index !== want.granted_index) begin
            $error("granted_index: expected %0d, actual %0d",
                   want.granted_index, out_item.granted_index);
            errors++;
          end
          if (out_item.granted_address !== want.granted_address) begin
            $error("granted_address: expected %h, actual %h",
                   want.granted_address, out_item.granted_address);
            errors++;
          end
          if (out_item.free_blocks !== want.free_blocks) begin
            $error("free_blocks: expected %0d, actual %0d",
                   want.free_blocks, out_item.free_blocks);
            errors++;
          end
        end
      end
      // A long hold lets the input side fill up and stall behind the held word.
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && idle_pct != 0 && $urandom_range(0, 399) < idle_pct) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/fbfl_pkg.sv
hw/rtl/fbfl_dp.sv
hw/rtl/fbfl_ctrl.sv
hw/rtl/fixed_block_free_list_allocator.sv
hw/rtl/fbfl_checker.sv
sim/testbench.sv
